[hdl/life_pkg.sv]
// Shared types and constants for the life automaton generation block.
package life_pkg;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_STEP  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // B3/S23: born on exactly three, kept on two or three
    localparam logic [3:0] LIVE_BIRTH = 4'd3;
    localparam logic [3:0] LIVE_KEEP  = 4'd2;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

[hdl/life_cell.sv]
// One column cell: holds a three-row window of its column and applies the B3/S23 rule.
module life_cell (
    input  logic       i_clk,
    input  logic       i_clear,
    input  logic       i_shift,
    input  logic       i_down,
    input  logic [1:0] i_left_vsum,
    input  logic [1:0] i_right_vsum,
    output logic [1:0] o_vsum,
    output logic       o_next
);

    logic       r_up;
    logic       r_mid;
    logic       n_up;
    logic       n_mid;
    logic [3:0] w_cnt;

    always_comb begin
        n_up  = r_up;
        n_mid = r_mid;
        if (i_clear) begin
            n_up  = 1'b0;
            n_mid = 1'b0;
        end else if (i_shift) begin
            n_up  = r_mid;
            n_mid = i_down;
        end
    end

    always_ff @(posedge i_clk) begin
        r_up  <= n_up;
        r_mid <= n_mid;
    end

    // column sum handed to both neighbors
    assign o_vsum = {1'b0, r_up} + {1'b0, r_mid} + {1'b0, i_down};

    assign w_cnt = {2'b00, i_left_vsum} + {2'b00, i_right_vsum}
                 + {3'b000, r_up} + {3'b000, i_down};

    assign o_next = (w_cnt == life_pkg::LIVE_BIRTH)
                 || (r_mid && (w_cnt == life_pkg::LIVE_KEEP));

endmodule

[hdl/life_mem.sv]
// Grid store: one row of cells per word, with per-row valid bits cleared at reset.
module life_mem #(
    parameter int ROWS = 64,
    parameter int COLS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  life_pkg::t_mem_ctl         i_ctl,
    input  logic [$clog2(ROWS)-1:0]    i_raddr,
    input  logic [$clog2(ROWS)-1:0]    i_waddr,
    input  logic [COLS-1:0]            i_wdata,
    output logic [COLS-1:0]            o_rdata
);

    logic [COLS-1:0] r_mem [ROWS];
    logic [ROWS-1:0] r_valid;
    logic [COLS-1:0] r_rdata;
    logic            r_rvalid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rvalid <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_valid[i_waddr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rvalid <= r_valid[i_raddr];
            end
        end
    end

    // a row never written since reset reads as all dead
    assign o_rdata = r_rvalid ? r_rdata : '0;

endmodule

[hdl/life_automaton_generation.sv]
// Top level of the life automaton generation block: sequencer, row of cells, grid store.
//
// Conway B3/S23 automaton on a GRID_ROWS by GRID_COLS grid, dead beyond the edges,
// all cells dead after reset. The grid is held one row per memory word. A write or
// read transfer passes through a row read, then a row write or result load, before the
// next acceptance; a read result waits in an output register, and a read holds in its
// wait state while an earlier result is still not taken. In a step, a row of GRID_COLS
// cells shifts one grid row per cycle through a three-row window; the store has one
// read and one write port. A read of a row or column outside the grid returns dead.
module life_automaton_generation #(
    parameter int GRID_ROWS = 64,
    parameter int GRID_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // row[5:0], col[11:6], cell_value[12], zero[15:13]
    input  logic [1:0]  i_s_tuser,   // action[1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // cell_alive[0], zero[7:1]
);

    localparam int RW = $clog2(GRID_ROWS);
    localparam int CW = $clog2(GRID_COLS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WRWAIT = 6'b000010,
        S_RDWAIT = 6'b000100,
        S_STEP   = 6'b001000,
        S_DRAIN  = 6'b010000,
        S_LAST   = 6'b100000
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [RW-1:0]      r_ridx;
    logic [RW-1:0]      n_ridx;
    logic [RW-1:0]      r_waddr;
    logic [RW-1:0]      n_waddr;
    logic               r_dv;
    logic               r_mid_ok;
    logic               n_mid_ok;
    logic [CW-1:0]      r_col_idx;
    logic               r_val;
    logic               r_inside;
    logic               r_m_tvalid;
    logic               n_m_tvalid;
    logic               r_m_alive;
    logic               n_m_alive;

    logic               w_accept;
    logic [1:0]         w_action;
    logic [5:0]         w_row;
    logic [5:0]         w_col;
    logic               w_inside;
    logic               w_clear;
    logic               w_shift;
    life_pkg::t_mem_ctl w_ctl;
    logic [RW-1:0]      w_raddr;
    logic [GRID_COLS-1:0] w_wdata;
    logic [GRID_COLS-1:0] w_rdata;
    logic [GRID_COLS-1:0] w_down;
    logic [GRID_COLS-1:0] w_next;
    logic [1:0]         w_vsum [GRID_COLS+2];

    assign w_action = i_s_tuser;
    assign w_row    = i_s_tdata[5:0];
    assign w_col    = i_s_tdata[11:6];
    assign w_inside = (int'(w_row) < GRID_ROWS) && (int'(w_col) < GRID_COLS);
    assign w_accept = i_s_tvalid && o_s_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {7'd0, r_m_alive};

    assign w_shift = r_dv;
    assign w_down  = (r_state == S_LAST) ? '0 : w_rdata;

    always_comb begin
        n_state    = r_state;
        n_ridx     = r_ridx;
        n_waddr    = r_waddr;
        n_mid_ok   = r_mid_ok;
        n_m_tvalid = r_m_tvalid && !i_m_tready;
        n_m_alive  = r_m_alive;
        w_clear    = 1'b0;
        w_ctl      = '0;
        w_raddr    = r_ridx;
        w_wdata    = w_next;
        case (r_state)
            S_IDLE: begin
                w_raddr = RW'(w_row);
                if (w_accept) begin
                    case (w_action)
                        life_pkg::ACT_WRITE: begin
                            w_ctl.rd_en = 1'b1;
                            n_waddr     = RW'(w_row);
                            n_state     = S_WRWAIT;
                        end
                        life_pkg::ACT_READ: begin
                            w_ctl.rd_en = 1'b1;
                            n_state     = S_RDWAIT;
                        end
                        life_pkg::ACT_STEP: begin
                            w_clear  = 1'b1;
                            n_ridx   = '0;
                            n_waddr  = '0;
                            n_mid_ok = 1'b0;
                            n_state  = S_STEP;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_WRWAIT: begin
                w_wdata            = w_rdata;
                w_wdata[r_col_idx] = r_val;
                w_ctl.wr_en        = r_inside;
                n_state            = S_IDLE;
            end
            S_RDWAIT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_alive  = r_inside && w_rdata[r_col_idx];
                    n_state    = S_IDLE;
                end
            end
            S_STEP: begin
                w_ctl.rd_en = 1'b1;
                n_ridx      = r_ridx + 1'b1;
                if (r_ridx == RW'(GRID_ROWS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_LAST;
            end
            S_LAST: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // new row for the window's middle row, written back behind the read pointer
        if ((r_state == S_STEP) || (r_state == S_DRAIN) || (r_state == S_LAST)) begin
            if ((r_dv && r_mid_ok) || (r_state == S_LAST)) begin
                w_ctl.wr_en = 1'b1;
                n_waddr     = r_waddr + 1'b1;
            end
            if (w_shift) begin
                n_mid_ok = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_dv       <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_dv       <= (r_state == S_STEP);
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx    <= n_ridx;
        r_waddr   <= n_waddr;
        r_mid_ok  <= n_mid_ok;
        r_m_alive <= n_m_alive;
        if (w_accept) begin
            r_col_idx <= CW'(w_col);
            r_val     <= i_s_tdata[12];
            r_inside  <= w_inside;
        end
    end

    life_mem #(
        .ROWS (GRID_ROWS),
        .COLS (GRID_COLS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_raddr (w_raddr),
        .i_waddr (r_waddr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // edges of the row see dead columns
    assign w_vsum[0]           = 2'd0;
    assign w_vsum[GRID_COLS+1] = 2'd0;

    for (genvar c = 0; c < GRID_COLS; c++) begin : g_cell
        life_cell u_cell (
            .i_clk        (i_clk),
            .i_clear      (w_clear),
            .i_shift      (w_shift),
            .i_down       (w_down[c]),
            .i_left_vsum  (w_vsum[c]),
            .i_right_vsum (w_vsum[c+2]),
            .o_vsum       (w_vsum[c+1]),
            .o_next       (w_next[c])
        );
    end

endmodule

[sim/testbench.sv]
// Self-checking testbench for life_automaton_generation: directed table, then random patterns.
module testbench;

    localparam int GRID_ROWS   = 64;
    localparam int GRID_COLS   = 64;
    localparam int BORN_COUNT  = 3;
    localparam int KEEP_COUNT  = 2;
    localparam int RANDOM_ITEMS = 110;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DIR_COUNT   = 24;

    // action code the block does not use
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0] act;
        logic [5:0] row;
        logic [5:0] col;
        logic       val;
        logic       fixed;   // expectation typed in below
        logic       alive;
    } t_life_cmd;

    logic        i_clk;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata  = '0;   // row[5:0], col[11:6], cell_value[12], zero[15:13]
    logic [1:0]  i_s_tuser  = '0;   // action[1:0]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;          // cell_alive[0], zero[7:1]

    logic [GRID_COLS-1:0] life_grid [GRID_ROWS];
    logic pending_alive [$];
    int   n_errors    = 0;
    int   send_quiet  = 0;
    int   recv_quiet  = 0;
    int   cycle_count = 0;

    t_life_cmd directed_cmds [DIR_COUNT] = '{
        '{life_pkg::ACT_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b0},
        '{life_pkg::ACT_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0},
        '{life_pkg::ACT_READ,  6'd21, 6'd42, 1'b1, 1'b1, 1'b0},
        '{life_pkg::ACT_WRITE, 6'd0,  6'd0,  1'b1, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd0,  6'd0,  1'b0, 1'b1, 1'b1},
        '{life_pkg::ACT_WRITE, 6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b1},
        '{life_pkg::ACT_WRITE, 6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0},
        '{ACT_SPARE,           6'd63, 6'd63, 1'b1, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd63, 6'd63, 1'b0, 1'b1, 1'b0},
        '{life_pkg::ACT_WRITE, 6'd0,  6'd1,  1'b1, 1'b0, 1'b0},
        '{life_pkg::ACT_WRITE, 6'd0,  6'd2,  1'b1, 1'b0, 1'b0},
        '{life_pkg::ACT_WRITE, 6'd0,  6'd63, 1'b1, 1'b0, 1'b0},
        '{life_pkg::ACT_WRITE, 6'd63, 6'd0,  1'b1, 1'b0, 1'b0},
        '{life_pkg::ACT_STEP,  6'd42, 6'd21, 1'b1, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd0,  6'd1,  1'b0, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd1,  6'd1,  1'b0, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd63, 6'd63, 1'b0, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd0,  6'd63, 1'b0, 1'b0, 1'b0},
        '{life_pkg::ACT_STEP,  6'd0,  6'd0,  1'b0, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd0,  6'd1,  1'b0, 1'b0, 1'b0},
        '{life_pkg::ACT_READ,  6'd1,  6'd1,  1'b0, 1'b0, 1'b0}
    };

    life_automaton_generation #(
        .GRID_ROWS(GRID_ROWS),
        .GRID_COLS(GRID_COLS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // next generation, edges count as dead
    function automatic void evolve_grid();
        logic [GRID_COLS-1:0] prev [GRID_ROWS];
        int n;
        int rr;
        int cc;
        prev = life_grid;
        for (int r = 0; r < GRID_ROWS; r++) begin
            for (int c = 0; c < GRID_COLS; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < GRID_ROWS &&
                            cc >= 0 && cc < GRID_COLS) begin
                            n += prev[rr][cc];
                        end
                    end
                end
                if (prev[r][c])
                    life_grid[r][c] = (n == KEEP_COUNT || n == BORN_COUNT);
                else
                    life_grid[r][c] = (n == BORN_COUNT);
            end
        end
    endfunction

    // updates the grid copy; returns the addressed cell for a read
    function automatic logic apply_cmd(input logic [1:0] act, input logic [5:0] row,
                                       input logic [5:0] col, input logic val);
        logic alive;
        alive = 1'b0;
        case (act)
            life_pkg::ACT_WRITE: begin
                life_grid[row][col] = val;
            end
            life_pkg::ACT_STEP: begin
                evolve_grid();
            end
            life_pkg::ACT_READ: begin
                alive = life_grid[row][col];
            end
            default: begin
            end
        endcase
        return alive;
    endfunction

    function automatic int draw_gap(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0) begin
            quiet_left = $urandom_range(8, 24);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic t_life_cmd make_cmd(input logic [1:0] act, input logic [5:0] row,
                                           input logic [5:0] col, input logic val);
        t_life_cmd cmd;
        cmd = '{act, row, col, val, 1'b0, 1'b0};
        return cmd;
    endfunction

    task automatic send_cmd(input t_life_cmd cmd);
        int   gap;
        logic alive;
        gap = draw_gap(send_quiet);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd.act;
        i_s_tdata  <= {3'b000, cmd.val, cmd.col, cmd.row};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        alive = apply_cmd(cmd.act, cmd.row, cmd.col, cmd.val);
        if (cmd.act == life_pkg::ACT_READ)
            pending_alive.push_back(cmd.fixed ? cmd.alive : alive);
    endtask

    // result side
    initial begin
        int   stall;
        logic want;
        wait (i_rst_n);
        forever begin
            stall = draw_gap(recv_quiet);
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!o_m_tvalid) @(posedge i_clk);
            if (pending_alive.size() == 0) begin
                n_errors++;
                $error("cell_alive: unexpected transfer, actual %0b", o_m_tdata[0]);
            end else begin
                want = pending_alive.pop_front();
                if (o_m_tdata[0] !== want) begin
                    n_errors++;
                    $error("cell_alive: expected %0b, actual %0b", want, o_m_tdata[0]);
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** life_automaton_generation: FAILED **");
        $finish;
    end

    initial begin
        int         sent;
        logic [5:0] r0;
        logic [5:0] c0;
        logic [1:0] act;
        for (int r = 0; r < GRID_ROWS; r++)
            life_grid[r] = '0;
        sent = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIR_COUNT; k++)
            send_cmd(directed_cmds[k]);

        // seed a small window, evolve it, then probe around it; or send random commands
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 7) begin
                r0 = 6'($urandom_range(0, 63));
                c0 = 6'($urandom_range(0, 63));
                if ($urandom_range(0, 3) == 0)
                    r0 = $urandom_range(0, 1) ? 6'd0 : 6'd60;
                if ($urandom_range(0, 3) == 0)
                    c0 = $urandom_range(0, 1) ? 6'd0 : 6'd60;
                repeat ($urandom_range(3, 8)) begin
                    send_cmd(make_cmd(life_pkg::ACT_WRITE, r0 + 6'($urandom_range(0, 3)),
                                      c0 + 6'($urandom_range(0, 3)),
                                      $urandom_range(0, 3) != 0));
                    sent++;
                end
                repeat ($urandom_range(1, 3)) begin
                    send_cmd(make_cmd(life_pkg::ACT_STEP, 6'($urandom_range(0, 63)),
                                      6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
                    sent++;
                end
                repeat ($urandom_range(3, 6)) begin
                    send_cmd(make_cmd(life_pkg::ACT_READ,
                                      r0 - 6'd1 + 6'($urandom_range(0, 5)),
                                      c0 - 6'd1 + 6'($urandom_range(0, 5)),
                                      1'($urandom_range(0, 1))));
                    sent++;
                end
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    act = 2'($urandom_range(0, 3));
                    send_cmd(make_cmd(act, 6'($urandom_range(0, 63)),
                                      6'($urandom_range(0, 63)), 1'($urandom_range(0, 1))));
                    sent++;
                end
            end
        end
        i_s_tvalid <= 1'b0;

        while (pending_alive.size() != 0) @(posedge i_clk);
        repeat (GRID_ROWS + 16) @(posedge i_clk);
        if (n_errors == 0)
            $display("** life_automaton_generation: PASSED **");
        else
            $display("** life_automaton_generation: FAILED **");
        $finish;
    end

endmodule
